// ===== hdl/modular_exponentiation_macros.svh =====
// assertion macros shared by the modular exponentiation rtl
// no dependencies; included by the files that carry assertions
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mexp_pkg.sv =====
// shared widths, defaults and payload types for modular exponentiation
// no dependencies
package mexp_pkg;
    localparam int BASE_W = 64;
    localparam int EXP_W  = 32;
    localparam int POW_W  = 32;
    localparam int MOD_W  = 32;

    localparam int EXP_BITS_DEF = 32;
    localparam int MOD_BITS_DEF = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = 32'd1000000007;

    typedef logic [BASE_W-1:0] t_base;
    typedef logic [EXP_W-1:0]  t_exponent;
    typedef logic [POW_W-1:0]  t_power;
    typedef logic [MOD_W-1:0]  t_modulus;
endpackage

// ===== hdl/mexp_ifs.sv =====
// valid/ready channel interfaces: request, response and modulus write
// depends on mexp_pkg
interface mexp_req_if;
    import mexp_pkg::*;
    logic      valid;
    logic      ready;
    t_base     base;
    t_exponent exponent;
    modport source (output valid, base, exponent, input ready);
    modport sink   (input valid, base, exponent, output ready);
endinterface

interface mexp_rsp_if;
    import mexp_pkg::*;
    logic   valid;
    logic   ready;
    t_power power;
    modport source (output valid, power, input ready);
    modport sink   (input valid, power, output ready);
endinterface

interface mexp_cfg_if;
    import mexp_pkg::*;
    logic     valid;
    logic     ready;
    t_modulus data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/modular_exponentiation.sv =====
// modular exponentiation top level: base^exponent mod a programmable modulus
// depends on mexp_pkg, mexp_ifs, mexp_mulmod and modular_exponentiation_macros.svh
// One request at a time. The 64-bit base is first reduced by the modulus, one bit per cycle;
// exponent bits are then scanned from the lsb up to the highest set bit, with a multiply
// into the result for each set bit and a squaring for each bit below the highest. Every
// multiply goes through the one shared bit-serial multiply-reduce unit; a request needs at
// most 2 * min(EXP_BITS, EXP_W) - 1 multiplies. A zero exponent needs no multiplies, and a
// zero modulus skips the reduction and gives result 0.
// The modulus register resets to 1000000007 and may only be rewritten while no request is open.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_cfg_if.sink    i_cfg,
    mexp_req_if.sink    i_req,
    mexp_rsp_if.source  o_rsp
);
    import mexp_pkg::*;

    localparam int EW = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam int CW = $clog2(BASE_W);
    localparam logic [CW-1:0] RED_LAST = CW'(BASE_W - 1);
    localparam logic [MOD_BITS-1:0] MOD_ONE = MOD_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_EXP,
        S_MUL,
        S_SQR,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [MOD_BITS-1:0] r_mod;
    logic [EW-1:0]       r_e;
    t_base               r_base;
    logic [CW-1:0]       r_cnt;
    logic [MOD_BITS-1:0] r_sq;
    logic [MOD_BITS-1:0] r_acc;
    logic                r_mm_start;
    logic                r_out_valid;
    t_power              r_power;

    logic [MOD_BITS:0]   w_red_t;
    logic [MOD_BITS:0]   w_red_n;
    logic [MOD_BITS-1:0] w_mm_x;
    logic                w_mm_done;
    logic [MOD_BITS-1:0] w_mm_res;

    // modulus register, to be written only between requests; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET[MOD_BITS-1:0];
        end else if (i_cfg.valid) begin
            r_mod <= i_cfg.data[MOD_BITS-1:0];
        end
    end
    assign i_cfg.ready = 1'b1;

    // base reduction: shift in one base bit, subtract m once if it fits
    always_comb begin
        w_red_t = {r_sq, r_base[BASE_W-1]};
        w_red_n = (w_red_t >= {1'b0, r_mod}) ? (w_red_t - {1'b0, r_mod}) : w_red_t;
    end

    assign w_mm_x = (r_state == S_MUL) ? r_acc : r_sq;

    mexp_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mm_start),
        .i_x      (w_mm_x),
        .i_y      (r_sq),
        .i_mod    (r_mod),
        .o_done   (w_mm_done),
        .o_result (w_mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= (r_state == S_EXP) && (r_e != '0);
            if ((r_state == S_FIN) && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_base <= i_req.base;
                        r_e    <= i_req.exponent[EW-1:0];
                        r_cnt  <= '0;
                        r_sq   <= '0;
                        r_acc  <= ((r_mod == MOD_ONE) || (r_mod == '0)) ? '0 : MOD_ONE;
                        // modulus zero has no reduction: answer 0 straight away
                        if (r_mod == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    r_sq   <= w_red_n[MOD_BITS-1:0];
                    r_base <= r_base << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == RED_LAST) begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_e == '0) begin
                        r_state <= S_FIN;
                    end else if (r_e[0]) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_mm_done) begin
                        r_acc   <= w_mm_res;
                        r_e[0]  <= 1'b0;
                        r_state <= S_EXP;
                    end
                end
                S_SQR: begin
                    if (w_mm_done) begin
                        r_sq    <= w_mm_res;
                        r_e     <= r_e >> 1;
                        r_state <= S_EXP;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_power <= POW_W'(r_acc);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.power = r_power;

    `MEXP_ASSERT_NEXT(a_request_starts, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != S_IDLE, "accepted request did not start")
    `MEXP_ASSERT_SAME(a_power_reduced, i_clk, i_rst_n, r_out_valid && (r_mod != '0), r_power < POW_W'(r_mod), "result not below modulus")
    `MEXP_ASSERT_SAME(a_multiply_needs_bits, i_clk, i_rst_n, (r_state == S_MUL) || (r_state == S_SQR), r_e != '0, "multiply with no exponent bits left")
endmodule

// ===== hdl/mexp_mulmod.sv =====
// bit-serial modular multiply: x * y mod m, one bit of y per cycle, msb first
// depends on mexp_pkg and modular_exponentiation_macros.svh
`include "modular_exponentiation_macros.svh"

module mexp_mulmod #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_x,
    input  logic [MOD_BITS-1:0] i_y,
    input  logic [MOD_BITS-1:0] i_mod,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_result
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(MOD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] r_x;
    logic [MOD_BITS-1:0] r_y;
    logic [MOD_BITS-1:0] r_r;

    logic [MOD_BITS:0]   w_m;
    logic [MOD_BITS:0]   w_dbl;
    logic [MOD_BITS:0]   w_dbl_red;
    logic [MOD_BITS:0]   w_sum;
    logic [MOD_BITS:0]   w_sum_red;

    // doubling then conditional add, each folded back below m
    always_comb begin
        w_m       = {1'b0, i_mod};
        w_dbl     = {r_r, 1'b0};
        w_dbl_red = (w_dbl >= w_m) ? (w_dbl - w_m) : w_dbl;
        w_sum     = w_dbl_red + (r_y[MOD_BITS-1] ? {1'b0, r_x} : '0);
        w_sum_red = (w_sum >= w_m) ? (w_sum - w_m) : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_r    <= '0;
            end else if (r_busy) begin
                r_r   <= w_sum_red[MOD_BITS-1:0];
                r_y   <= r_y << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

    `MEXP_ASSERT_SAME(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy, "mulmod started while busy")
    `MEXP_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && (r_cnt == CNT_LAST), r_done, "mulmod missed done")
    `MEXP_ASSERT_SAME(a_result_reduced, i_clk, i_rst_n, r_done && (i_mod != '0), r_r < i_mod, "mulmod result not reduced")
endmodule
